// ----- rtl/frame_escape_xor_encoder_unit_assert.svh -----
// Assertion macros used by the encoder top level.
`ifndef FRAME_ESCAPE_XOR_ENCODER_UNIT_ASSERT_SVH
`define FRAME_ESCAPE_XOR_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define FXE_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("frame encoder check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define FXE_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("frame encoder check failed");

`endif

// ----- rtl/fxe_pkg.sv -----
package fxe_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_OF_7D = 8'h01;
  localparam logic [7:0] ESC_OF_7E = 8'h02;

  localparam int QUEUE_DEPTH = 2;

  // One classified input word, ready for expansion.
  typedef struct packed {
    logic       open;
    logic [7:0] data;
    logic       last;
    logic [7:0] csum;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == ESC_BYTE) || (b == FLAG_BYTE);
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] b);
    return (b == ESC_BYTE) ? ESC_OF_7D : ESC_OF_7E;
  endfunction

endpackage

// ----- rtl/fxe_front.sv -----
module fxe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  fxe_pkg::qstat_t qstat,
  output logic          push,
  output fxe_pkg::cmd_t push_cmd
);
  import fxe_pkg::*;

  logic       in_frame;
  logic [7:0] running_xor;
  logic [7:0] csum_next;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  // A word that opens a frame starts the checksum from zero.
  assign csum_next = (in_frame ? running_xor : 8'h00) ^ data_byte;

  always_comb begin
    push_cmd.open = !in_frame;
    push_cmd.data = data_byte;
    push_cmd.last = last_byte;
    push_cmd.csum = csum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      running_xor <= 8'h00;
    end else if (push) begin
      if (last_byte) begin
        in_frame    <= 1'b0;
        running_xor <= 8'h00;
      end else begin
        in_frame    <= 1'b1;
        running_xor <= csum_next;
      end
    end
  end

endmodule

// ----- rtl/fxe_queue.sv -----
module fxe_queue #(
  parameter int DEPTH = fxe_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fxe_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output fxe_pkg::cmd_t   head,
  output fxe_pkg::qstat_t qstat
);
  import fxe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] FULL_COUNT = DEPTH[AW:0];

  cmd_t        entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == FULL_COUNT);
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fxe_back.sv -----
module fxe_back (
  input  logic            clk,
  input  logic            rst,
  input  fxe_pkg::cmd_t   head,
  input  fxe_pkg::qstat_t qstat,
  output logic            pop,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            frame_end
);
  import fxe_pkg::*;

  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_DATA2 = 3'd2;
  localparam logic [2:0] PH_CSUM  = 3'd3;
  localparam logic [2:0] PH_CSUM2 = 3'd4;
  localparam logic [2:0] PH_CLOSE = 3'd5;

  logic [2:0] phase;
  logic [2:0] cur_phase;
  logic [2:0] phase_next;
  logic       done;
  logic       load;
  logic [7:0] byte_next;
  logic       end_next;

  // A fresh word starts at the opening flag or directly at its data byte.
  assign cur_phase = busy ? phase : (head.open ? PH_OPEN : PH_DATA);
  assign load      = !qstat.empty && (!out_valid || out_ready);
  assign pop       = load && done;

  always_comb begin
    byte_next  = head.data;
    end_next   = 1'b0;
    phase_next = PH_DATA;
    done       = 1'b0;
    case (cur_phase)
      PH_OPEN: begin
        byte_next  = FLAG_BYTE;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (needs_escape(head.data)) begin
          byte_next  = ESC_BYTE;
          phase_next = PH_DATA2;
        end else begin
          byte_next  = head.data;
          phase_next = PH_CSUM;
          done       = !head.last;
        end
      end
      PH_DATA2: begin
        byte_next  = escape_code(head.data);
        phase_next = PH_CSUM;
        done       = !head.last;
      end
      PH_CSUM: begin
        if (needs_escape(head.csum)) begin
          byte_next  = ESC_BYTE;
          phase_next = PH_CSUM2;
        end else begin
          byte_next  = head.csum;
          phase_next = PH_CLOSE;
        end
      end
      PH_CSUM2: begin
        byte_next  = escape_code(head.csum);
        phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_next = FLAG_BYTE;
        end_next  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        byte_next = head.data;
        done      = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_OPEN;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !done;
        phase     <= phase_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_next;
      frame_end <= end_next;
    end
  end

endmodule

// ----- rtl/frame_escape_xor_encoder_unit.sv -----
// Channel  Signals                              Direction  Word
// input    in_valid, in_ready, data_byte, ...   in         one raw message byte
// output   out_valid, out_ready, out_byte, ...  out        one framed byte
//
// Each input word becomes one or more framed bytes: a plain byte inside a frame
// gives one byte, while a word that opens or closes a frame also brings flags,
// a checksum and any escapes. The back end's byte sequencer and its single
// output register emit them; a small queue lets the front keep accepting
// while it expands. Reset clears the frame state, the queue and the output
// valid flag. An output stall backs up into the queue and then drops in_ready.
module frame_escape_xor_encoder_unit #(
  parameter int QUEUE_DEPTH = fxe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_end
);
  import fxe_pkg::*;

  `include "frame_escape_xor_encoder_unit_assert.svh"

  cmd_t   push_cmd;
  cmd_t   head;
  qstat_t qstat;
  logic   push;
  logic   pop;
  logic   back_busy;

  fxe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  fxe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  fxe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

  // The closing word of a frame is always the flag byte.
  `FXE_ASSERT_IMP(a_end_is_flag, out_valid && frame_end, out_byte == FLAG_BYTE)
  // A word in the middle of expansion still sits at the queue head.
  `FXE_ASSERT_IMP(a_busy_has_head, back_busy, !qstat.empty)
  // An accepted word is in the queue on the next cycle.
  `FXE_ASSERT_NEXT(a_push_lands, !rst && in_valid && in_ready, !qstat.empty)

endmodule

// ----- tb/frame_escape_xor_encoder_unit_tb.sv -----
module frame_escape_xor_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fxe_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_WORDS = 410;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } framed_t;

  // Tracks the open frame and the framed bytes that are still owed by the block.
  class frame_checker;
    logic [7:0] csum;
    bit         open;
    framed_t    due[$];
    int         errors;
    int         words_in;
    int         words_out;
    int         frames;

    function new();
      csum      = 8'h00;
      open      = 1'b0;
      errors    = 0;
      words_in  = 0;
      words_out = 0;
      frames    = 0;
    endfunction

    function void push_escaped(logic [7:0] b);
      if (b == ESC_BYTE) begin
        due.push_back('{ESC_BYTE, 1'b0});
        due.push_back('{ESC_OF_7D, 1'b0});
      end else if (b == FLAG_BYTE) begin
        due.push_back('{ESC_BYTE, 1'b0});
        due.push_back('{ESC_OF_7E, 1'b0});
      end else begin
        due.push_back('{b, 1'b0});
      end
    endfunction

    function void note_word(logic [7:0] data, logic last);
      words_in++;
      if (!open) begin
        due.push_back('{FLAG_BYTE, 1'b0});
        open = 1'b1;
        csum = 8'h00;
      end
      push_escaped(data);
      csum ^= data;
      if (last) begin
        push_escaped(csum);
        due.push_back('{FLAG_BYTE, 1'b1});
        csum = 8'h00;
        open = 1'b0;
        frames++;
      end
    endfunction

    function void check_word(logic [7:0] b, logic fin);
      framed_t want;
      words_out++;
      if (due.size() == 0) begin
        $error("unexpected output word: out_byte %h frame_end %b", b, fin);
        errors++;
        return;
      end
      want = due.pop_front();
      if (b !== want.b) begin
        $error("out_byte: expected %h, actual %h", want.b, b);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("frame_end: expected %b, actual %b", want.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       frame_end;

  // When set, both sides run without idle cycles.
  bit          fast;
  int          sent;
  frame_checker book = new();

  frame_escape_xor_encoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) book.note_word(data_byte, last_byte);
      if (out_valid && out_ready) book.check_word(out_byte, frame_end);
    end
  end

  task automatic send_word(input logic [7:0] d, input logic l);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    data_byte = d;
    last_byte = l;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // A goal of -1 leaves the checksum to chance; otherwise the last byte forces it.
  task automatic send_frame(input int len, input int csum_goal);
    logic [7:0] x;
    logic [7:0] d;
    x = 8'h00;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
      else d = 8'($urandom_range(0, 255));
      if (i == len - 1 && csum_goal >= 0) d = x ^ csum_goal[7:0];
      x ^= d;
      send_word(d, i == len - 1);
    end
  endtask

  // Output side: a random stall before each word, none while fast is set.
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = fast ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int len;
    int goal;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    fast      = 1'b0;
    sent      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-byte frames at the extremes and on both escape codes.
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    send_word(ESC_BYTE, 1'b1);
    send_word(FLAG_BYTE, 1'b1);
    // Escapes inside a frame and a plain checksum.
    send_word(FLAG_BYTE, 1'b0);
    send_word(ESC_BYTE, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'haa, 1'b1);
    // Checksum lands on the flag value, then on the escape value.
    send_word(8'h7c, 1'b0);
    send_word(8'h02, 1'b1);
    send_word(8'h7c, 1'b0);
    send_word(8'h01, 1'b1);
    // Checksum folds back to zero.
    send_word(ESC_BYTE, 1'b0);
    send_word(ESC_BYTE, 1'b1);
    // Back-to-back words with no idling on either side.
    fast = 1'b1;
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'hfe, 1'b1);
    send_word(FLAG_BYTE, 1'b1);
    fast = 1'b0;

    while (sent < TARGET_WORDS) begin
      fast = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(40, 80);
        1, 2:    len = $urandom_range(13, 30);
        default: len = $urandom_range(1, 12);
      endcase
      if (len > TARGET_WORDS - sent) len = TARGET_WORDS - sent;
      case ($urandom_range(0, 9))
        0:       goal = int'(FLAG_BYTE);
        1:       goal = int'(ESC_BYTE);
        default: goal = -1;
      endcase
      send_frame(len, goal);
    end
    fast = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d frames and checked %0d framed words,",
             book.words_in, book.frames, book.words_out);
    $display("covering escaped data, escaped checksums and random stalls on both sides.");
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- frame_escape_xor_encoder_unit.f -----
+incdir+rtl
rtl/fxe_pkg.sv
rtl/fxe_front.sv
rtl/fxe_queue.sv
rtl/fxe_back.sv
rtl/frame_escape_xor_encoder_unit.sv
tb/frame_escape_xor_encoder_unit_tb.sv
